### rtl/core/atfci_pkg.sv
`default_nettype none

package atfci_pkg;

  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;

  localparam logic [1:0] CFG_DISK_PRESENT    = 2'd0;
  localparam logic [1:0] CFG_TOTAL_SECTORS   = 2'd1;
  localparam logic [1:0] CFG_LBA48_SUPPORTED = 2'd2;

  localparam logic [1:0] KIND_REJECT = 2'd0;
  localparam logic [1:0] KIND_FLUSH  = 2'd1;
  localparam logic [1:0] KIND_LBA28  = 2'd2;
  localparam logic [1:0] KIND_LBA48  = 2'd3;

  localparam logic [2:0] REG_NONE   = 3'd0;
  localparam logic [2:0] REG_COUNT  = 3'd2;
  localparam logic [2:0] REG_LBA_LO = 3'd3;
  localparam logic [2:0] REG_LBA_MI = 3'd4;
  localparam logic [2:0] REG_LBA_HI = 3'd5;
  localparam logic [2:0] REG_DRIVE  = 3'd6;
  localparam logic [2:0] REG_CMD    = 3'd7;

  localparam logic [7:0] DRIVE_LBA28    = 8'hE0;
  localparam logic [7:0] DRIVE_LBA48    = 8'h40;
  localparam logic [7:0] CMD_READ_EXT   = 8'h24;
  localparam logic [7:0] CMD_WRITE_EXT  = 8'h34;
  localparam logic [7:0] CMD_READ       = 8'h20;
  localparam logic [7:0] CMD_WRITE      = 8'h30;
  localparam logic [7:0] CMD_FLUSH      = 8'hE7;
  localparam logic [48:0] LBA28_TOP     = 49'h0_0000_0FFF_FFFF;

  localparam logic [3:0] LAST_STEP_LBA28 = 4'd5;
  localparam logic [3:0] LAST_STEP_LBA48 = 4'd9;

  typedef struct packed {
    logic [1:0]  func;
    logic [47:0] sector_address;
    logic [7:0]  sector_count;
  } req_t;

  typedef struct packed {
    logic [2:0] reg_offset;
    logic [7:0] reg_value;
    logic       rejected;
    logic       last;
  } rsp_t;

  typedef struct packed {
    logic        disk_present;
    logic [47:0] total_sectors;
    logic        lba48_supported;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        is_write;
    logic [47:0] lba;
    logic [7:0]  count;
  } job_t;

endpackage

`default_nettype wire

### rtl/core/atfci_front.sv
`default_nettype none

module atfci_front (
  input  var atfci_pkg::req_t req_data,
  input  var atfci_pkg::cfg_t cfg,
  output atfci_pkg::job_t     job
);

  logic [48:0] end_lba;
  logic        bad;
  logic        use48;

  always_comb begin
    end_lba = {1'b0, req_data.sector_address} + {41'b0, req_data.sector_count};
    bad = !(req_data.func inside {atfci_pkg::FUNC_READ, atfci_pkg::FUNC_WRITE,
                                  atfci_pkg::FUNC_FLUSH})
          || !cfg.disk_present
          || (req_data.sector_count == 8'd0)
          || (end_lba > {1'b0, cfg.total_sectors});
    use48 = cfg.lba48_supported && (end_lba > atfci_pkg::LBA28_TOP);

    job.is_write = (req_data.func == atfci_pkg::FUNC_WRITE);
    job.lba      = req_data.sector_address;
    job.count    = req_data.sector_count;
    if (bad) begin
      job.kind = atfci_pkg::KIND_REJECT;
    end else if (req_data.func == atfci_pkg::FUNC_FLUSH) begin
      job.kind = atfci_pkg::KIND_FLUSH;
    end else if (use48) begin
      job.kind = atfci_pkg::KIND_LBA48;
    end else begin
      job.kind = atfci_pkg::KIND_LBA28;
    end
  end

endmodule

`default_nettype wire

### rtl/core/atfci_queue.sv
`default_nettype none

module atfci_queue #(
  parameter int DEPTH = 2
) (
  input  var logic            clk,
  input  var logic            rst,
  input  var logic            push,
  input  var atfci_pkg::job_t push_data,
  input  var logic            pop,
  output logic                full,
  output logic                nonempty,
  output atfci_pkg::job_t     head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  atfci_pkg::job_t entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   fill;

  assign full     = (fill == CNT_FULL);
  assign nonempty = (fill != '0);
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("pop from an empty queue");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= CNT_FULL)
    else $error("queue fill out of range");
`endif

endmodule

`default_nettype wire

### rtl/core/atfci_back.sv
`default_nettype none

module atfci_back (
  input  var logic            clk,
  input  var logic            rst,
  input  var logic            job_valid,
  input  var atfci_pkg::job_t job,
  output logic                job_pop,
  output logic                rsp_valid,
  input  var logic            rsp_stall,
  output atfci_pkg::rsp_t     rsp_data
);

  logic [3:0]      step;
  logic            load;
  atfci_pkg::rsp_t item;
  logic [7:0]      cmd28;
  logic [7:0]      cmd48;

  always_comb begin
    cmd28 = job.is_write ? atfci_pkg::CMD_WRITE : atfci_pkg::CMD_READ;
    cmd48 = job.is_write ? atfci_pkg::CMD_WRITE_EXT : atfci_pkg::CMD_READ_EXT;
    item.rejected   = 1'b0;
    item.last       = 1'b0;
    item.reg_offset = atfci_pkg::REG_NONE;
    item.reg_value  = 8'h00;
    case (job.kind)
      atfci_pkg::KIND_REJECT: begin
        item.rejected = 1'b1;
        item.last     = 1'b1;
      end
      atfci_pkg::KIND_FLUSH: begin
        item.reg_offset = atfci_pkg::REG_CMD;
        item.reg_value  = atfci_pkg::CMD_FLUSH;
        item.last       = 1'b1;
      end
      atfci_pkg::KIND_LBA28: begin
        item.last = (step == atfci_pkg::LAST_STEP_LBA28);
        case (step)
          4'd0: begin
            item.reg_offset = atfci_pkg::REG_DRIVE;
            item.reg_value  = atfci_pkg::DRIVE_LBA28 | {4'h0, job.lba[27:24]};
          end
          4'd1: begin
            item.reg_offset = atfci_pkg::REG_COUNT;
            item.reg_value  = job.count;
          end
          4'd2: begin
            item.reg_offset = atfci_pkg::REG_LBA_LO;
            item.reg_value  = job.lba[7:0];
          end
          4'd3: begin
            item.reg_offset = atfci_pkg::REG_LBA_MI;
            item.reg_value  = job.lba[15:8];
          end
          4'd4: begin
            item.reg_offset = atfci_pkg::REG_LBA_HI;
            item.reg_value  = job.lba[23:16];
          end
          default: begin
            item.reg_offset = atfci_pkg::REG_CMD;
            item.reg_value  = cmd28;
          end
        endcase
      end
      default: begin
        item.last = (step == atfci_pkg::LAST_STEP_LBA48);
        case (step)
          4'd0: begin
            item.reg_offset = atfci_pkg::REG_COUNT;
            item.reg_value  = 8'h00;
          end
          4'd1: begin
            item.reg_offset = atfci_pkg::REG_LBA_LO;
            item.reg_value  = job.lba[31:24];
          end
          4'd2: begin
            item.reg_offset = atfci_pkg::REG_LBA_MI;
            item.reg_value  = job.lba[39:32];
          end
          4'd3: begin
            item.reg_offset = atfci_pkg::REG_LBA_HI;
            item.reg_value  = job.lba[47:40];
          end
          4'd4: begin
            item.reg_offset = atfci_pkg::REG_COUNT;
            item.reg_value  = job.count;
          end
          4'd5: begin
            item.reg_offset = atfci_pkg::REG_LBA_LO;
            item.reg_value  = job.lba[7:0];
          end
          4'd6: begin
            item.reg_offset = atfci_pkg::REG_LBA_MI;
            item.reg_value  = job.lba[15:8];
          end
          4'd7: begin
            item.reg_offset = atfci_pkg::REG_LBA_HI;
            item.reg_value  = job.lba[23:16];
          end
          4'd8: begin
            item.reg_offset = atfci_pkg::REG_DRIVE;
            item.reg_value  = atfci_pkg::DRIVE_LBA48;
          end
          default: begin
            item.reg_offset = atfci_pkg::REG_CMD;
            item.reg_value  = cmd48;
          end
        endcase
      end
    endcase
  end

  assign load    = job_valid && (!rsp_valid || !rsp_stall);
  assign job_pop = load && item.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      step      <= 4'd0;
    end else if (load) begin
      rsp_valid <= 1'b1;
      step      <= item.last ? 4'd0 : step + 4'd1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_data <= item;
    end
  end

`ifndef SYNTHESIS
  a_reject_is_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.rejected |-> rsp_data.last)
    else $error("rejected result not marked last");
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    step <= atfci_pkg::LAST_STEP_LBA48)
    else $error("step counter out of range");
  a_step_restart: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> step == 4'd0)
    else $error("step counter not restarted after a request");
`endif

endmodule

`default_nettype wire

### rtl/core/ata_task_file_command_issuer.sv
// Channel   | Valid      | Stall      | Payload
// request   | req_valid  | req_stall  | req_data  (func, sector_address, sector_count)
// response  | rsp_valid  | rsp_stall  | rsp_data  (reg_offset, reg_value, rejected, last)
// config    | cfg_we     | -          | cfg_index, cfg_data
//
// A request gives 1 result (reject or flush), 6 (LBA28) or 10 (LBA48), one per cycle
// while rsp_stall is low; the first is registered at the output after the queue.
// Requests enter a QUEUE_DEPTH-entry queue; req_stall is high only while it is full.
// While valid, rsp_stall holds the back end's output register and step counter.
// Synchronous reset empties the queue and clears all configuration to zero.
`default_nettype none

module ata_task_file_command_issuer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  var logic             clk,
  input  var logic             rst,
  input  var logic             cfg_we,
  input  var logic [1:0]       cfg_index,
  input  var logic [47:0]      cfg_data,
  input  var logic             req_valid,
  output logic                 req_stall,
  input  var atfci_pkg::req_t  req_data,
  output logic                 rsp_valid,
  input  var logic             rsp_stall,
  output atfci_pkg::rsp_t      rsp_data
);

  atfci_pkg::cfg_t cfg;
  atfci_pkg::job_t new_job;
  atfci_pkg::job_t head;
  logic            q_full;
  logic            q_nonempty;
  logic            q_pop;
  logic            push;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        atfci_pkg::CFG_DISK_PRESENT:    cfg.disk_present    <= cfg_data[0];
        atfci_pkg::CFG_TOTAL_SECTORS:   cfg.total_sectors   <= cfg_data;
        atfci_pkg::CFG_LBA48_SUPPORTED: cfg.lba48_supported <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign req_stall = q_full;
  assign push      = req_valid && !q_full;

  atfci_front u_front (
    .req_data (req_data),
    .cfg      (cfg),
    .job      (new_job)
  );

  atfci_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (new_job),
    .pop       (q_pop),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .head      (head)
  );

  atfci_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_nonempty),
    .job       (head),
    .job_pop   (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule

`default_nettype wire

### dv/tb.sv
module tb;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [47:0] LBA_MAX = 48'hFFFF_FFFF_FFFF;
  localparam int TAIL_CYCLES = 12;
  localparam int LONG_HOLD_CYCLES = 150;

  class task_file_checker;
    atfci_pkg::rsp_t due_writes[$];
    logic disk_present = 1'b0;
    logic [47:0] total_sectors = '0;
    logic lba48_supported = 1'b0;
    int mismatches = 0;

    function void set_register(logic [1:0] index, logic [47:0] value);
      case (index)
        atfci_pkg::CFG_DISK_PRESENT: begin
          disk_present = value[0];
        end
        atfci_pkg::CFG_TOTAL_SECTORS: begin
          total_sectors = value;
        end
        atfci_pkg::CFG_LBA48_SUPPORTED: begin
          lba48_supported = value[0];
        end
        default: begin
        end
      endcase
    endfunction

    function void queue_write(logic [2:0] offset, logic [7:0] value, logic rej, logic fin);
      atfci_pkg::rsp_t w;
      w.reg_offset = offset;
      w.reg_value = value;
      w.rejected = rej;
      w.last = fin;
      due_writes.push_back(w);
    endfunction

    function void note_request(atfci_pkg::req_t r);
      logic [48:0] end_lba;
      logic [47:0] a;
      logic is_read;
      end_lba = {1'b0, r.sector_address} + {41'd0, r.sector_count};
      a = r.sector_address;
      is_read = (r.func == atfci_pkg::FUNC_READ);
      if (r.func == FUNC_UNUSED || !disk_present || r.sector_count == 8'd0 ||
          end_lba > {1'b0, total_sectors}) begin
        queue_write(atfci_pkg::REG_NONE, 8'h00, 1'b1, 1'b1);
      end else if (r.func == atfci_pkg::FUNC_FLUSH) begin
        queue_write(atfci_pkg::REG_CMD, atfci_pkg::CMD_FLUSH, 1'b0, 1'b1);
      end else if (lba48_supported && end_lba > atfci_pkg::LBA28_TOP) begin
        queue_write(atfci_pkg::REG_COUNT, 8'h00, 1'b0, 1'b0);
        queue_write(atfci_pkg::REG_LBA_LO, a[31:24], 1'b0, 1'b0);
        queue_write(atfci_pkg::REG_LBA_MI, a[39:32], 1'b0, 1'b0);
        queue_write(atfci_pkg::REG_LBA_HI, a[47:40], 1'b0, 1'b0);
        queue_write(atfci_pkg::REG_COUNT, r.sector_count, 1'b0, 1'b0);
        queue_write(atfci_pkg::REG_LBA_LO, a[7:0], 1'b0, 1'b0);
        queue_write(atfci_pkg::REG_LBA_MI, a[15:8], 1'b0, 1'b0);
        queue_write(atfci_pkg::REG_LBA_HI, a[23:16], 1'b0, 1'b0);
        queue_write(atfci_pkg::REG_DRIVE, atfci_pkg::DRIVE_LBA48, 1'b0, 1'b0);
        queue_write(atfci_pkg::REG_CMD,
                    is_read ? atfci_pkg::CMD_READ_EXT : atfci_pkg::CMD_WRITE_EXT,
                    1'b0, 1'b1);
      end else begin
        queue_write(atfci_pkg::REG_DRIVE, atfci_pkg::DRIVE_LBA28 | {4'h0, a[27:24]},
                    1'b0, 1'b0);
        queue_write(atfci_pkg::REG_COUNT, r.sector_count, 1'b0, 1'b0);
        queue_write(atfci_pkg::REG_LBA_LO, a[7:0], 1'b0, 1'b0);
        queue_write(atfci_pkg::REG_LBA_MI, a[15:8], 1'b0, 1'b0);
        queue_write(atfci_pkg::REG_LBA_HI, a[23:16], 1'b0, 1'b0);
        queue_write(atfci_pkg::REG_CMD, is_read ? atfci_pkg::CMD_READ : atfci_pkg::CMD_WRITE,
                    1'b0, 1'b1);
      end
    endfunction

    function void check_write(atfci_pkg::rsp_t got);
      atfci_pkg::rsp_t want;
      if (due_writes.size() == 0) begin
        $error("unexpected register write: offset %0d value %02h rejected %0b last %0b",
               got.reg_offset, got.reg_value, got.rejected, got.last);
        mismatches++;
        return;
      end
      want = due_writes.pop_front();
      if (got.reg_offset !== want.reg_offset) begin
        $error("reg_offset: expected %0d, got %0d", want.reg_offset, got.reg_offset);
        mismatches++;
      end
      if (got.reg_value !== want.reg_value) begin
        $error("reg_value: expected %02h, got %02h", want.reg_value, got.reg_value);
        mismatches++;
      end
      if (got.rejected !== want.rejected) begin
        $error("rejected: expected %0b, got %0b", want.rejected, got.rejected);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = atfci_pkg::CFG_DISK_PRESENT;
  logic [47:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  atfci_pkg::req_t req_data = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  atfci_pkg::rsp_t rsp_data;

  task_file_checker tracker;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  bit long_hold_armed = 1'b0;

  ata_task_file_command_issuer dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data(rsp_data)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (long_hold_armed) begin
      long_hold_armed = 1'b0;
      hold_left = LONG_HOLD_CYCLES - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      tracker.check_write(rsp_data);
    end
  end

  function automatic logic [47:0] random_lba();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  task automatic send_request(input logic [1:0] f, input logic [47:0] a,
                              input logic [7:0] n);
    atfci_pkg::req_t r;
    r.func = f;
    r.sector_address = a;
    r.sector_count = n;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    tracker.note_request(r);
  endtask

  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (tracker.due_writes.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic configure(input logic dp, input logic [47:0] total, input logic l48);
    logic [1:0] idx [3] = '{atfci_pkg::CFG_DISK_PRESENT, atfci_pkg::CFG_TOTAL_SECTORS,
                            atfci_pkg::CFG_LBA48_SUPPORTED};
    logic [47:0] vals [3];
    logic [47:0] pad;
    pad = random_lba();
    vals[0] = {pad[47:1], dp};
    vals[1] = total;
    vals[2] = {pad[47:1], l48};
    for (int i = 0; i < 3; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      tracker.set_register(idx[i], vals[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_configure();
    logic [47:0] total;
    case ($urandom_range(3))
      0: total = LBA_MAX;
      1: total = random_lba();
      2: total = 48'h0FFF_FC00 + 48'($urandom_range(2047));
      default: total = 48'($urandom_range(5000));
    endcase
    configure($urandom_range(9) != 0, total, 1'($urandom_range(1)));
  endtask

  task automatic random_request();
    logic [1:0] f;
    logic [47:0] a;
    logic [7:0] n;
    int pick;
    pick = $urandom_range(15);
    f = pick < 5 ? atfci_pkg::FUNC_READ : pick < 10 ? atfci_pkg::FUNC_WRITE :
        pick < 14 ? atfci_pkg::FUNC_FLUSH : FUNC_UNUSED;
    n = ($urandom_range(11) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    case ($urandom_range(3))
      0: a = random_lba();
      1: a = 48'h0FFF_FF00 + 48'($urandom_range(511));
      2: a = tracker.total_sectors - 48'($urandom_range(300));
      default: a = 48'($urandom_range(28'hFFF_FFFF));
    endcase
    send_request(f, a, n);
  endtask

  initial begin
    #4000000;
    $display("ata_task_file_command_issuer regression: fail");
    $finish;
  end

  initial begin
    tracker = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 30;
    recv_idle_pct = 77;
    send_request(atfci_pkg::FUNC_READ, 48'd0, 8'd1);
    send_request(atfci_pkg::FUNC_FLUSH, 48'd5, 8'd1);
    drain();

    configure(1'b1, LBA_MAX, 1'b1);
    send_request(atfci_pkg::FUNC_READ, 48'd0, 8'd1);
    send_request(atfci_pkg::FUNC_WRITE, 48'h0FFF_FFFE, 8'd1);
    send_request(atfci_pkg::FUNC_WRITE, 48'h0FFF_FFFF, 8'd1);
    send_request(atfci_pkg::FUNC_READ, 48'hFFFF_FFFF_FF00, 8'd255);
    send_request(atfci_pkg::FUNC_READ, LBA_MAX, 8'd1);
    send_request(atfci_pkg::FUNC_READ, 48'h5555_AAAA_5555, 8'hAA);
    send_request(atfci_pkg::FUNC_WRITE, 48'hAAAA_5555_AAAA, 8'h55);
    send_request(atfci_pkg::FUNC_FLUSH, 48'd0, 8'd1);
    send_request(FUNC_UNUSED, 48'd100, 8'd4);
    send_request(atfci_pkg::FUNC_READ, 48'd100, 8'd0);
    send_request(atfci_pkg::FUNC_FLUSH, 48'd100, 8'd0);
    drain();

    configure(1'b1, LBA_MAX, 1'b0);
    send_request(atfci_pkg::FUNC_READ, 48'h1234_5678_9ABC, 8'd16);
    send_request(atfci_pkg::FUNC_WRITE, 48'hFFFF_FFFF_FF00, 8'd255);
    drain();

    configure(1'b1, 48'd1000, 1'b1);
    send_request(atfci_pkg::FUNC_READ, 48'd990, 8'd10);
    send_request(atfci_pkg::FUNC_READ, 48'd991, 8'd10);
    send_request(atfci_pkg::FUNC_FLUSH, 48'd1000, 8'd1);
    send_request(atfci_pkg::FUNC_FLUSH, 48'd999, 8'd1);
    drain();

    configure(1'b1, 48'd0, 1'b1);
    send_request(atfci_pkg::FUNC_READ, 48'd0, 8'd1);
    drain();

    configure(1'b0, LBA_MAX, 1'b1);
    send_request(atfci_pkg::FUNC_WRITE, 48'd0, 8'd1);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      send_idle_pct = phase < 2 ? 30 : phase < 4 ? 77 : 0;
      recv_idle_pct = phase < 2 ? 77 : phase < 4 ? 30 : 0;
      random_configure();
      if (phase == 4) begin
        long_hold_armed = 1'b1;
      end
      repeat (18) random_request();
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.due_writes.size() == 0) begin
      $display("ata_task_file_command_issuer regression: pass");
    end else begin
      $display("ata_task_file_command_issuer regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/atfci_pkg.sv
rtl/core/atfci_front.sv
rtl/core/atfci_queue.sv
rtl/core/atfci_back.sv
rtl/core/ata_task_file_command_issuer.sv
dv/tb.sv
